/* sv/bqd_pkg.sv */
// Shared constants, types and codes for the biquad filter.
`timescale 1ns / 1ps
`default_nettype none

package bqd_pkg;

	// Word and arithmetic widths
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 22;
	localparam int COEF_BITS      = 24;
	localparam int DELAY_BITS     = 32;
	localparam int PROD_BITS      = COEF_BITS + DELAY_BITS;
	localparam int XSCL_BITS      = SAMPLE_BITS + COEF_FRAC_BITS;
	localparam int ACC_BITS       = ((PROD_BITS > XSCL_BITS) ? PROD_BITS : XSCL_BITS) + 2;

	// Configuration port
	localparam int CFG_REGS     = 5;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_B0 = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_B1 = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] CFG_B2 = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] CFG_A1 = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] CFG_A2 = CFG_IDX_BITS'(4);

	// Reset coefficients: unity gain on b0, everything else zero
	localparam logic signed [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(1) <<< COEF_FRAC_BITS;
	localparam logic signed [COEF_BITS-1:0] COEF_ZERO = '0;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] b0;
		logic signed [COEF_BITS-1:0] b1;
		logic signed [COEF_BITS-1:0] b2;
		logic signed [COEF_BITS-1:0] a1;
		logic signed [COEF_BITS-1:0] a2;
	} coef_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A2,
		ST_WSUM,
		ST_WSAT,
		ST_B0,
		ST_B2,
		ST_YSUM,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MUL_A1,
		MUL_A2,
		MUL_B0,
		MUL_B1,
		MUL_B2
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_X,
		ACC_SUB,
		ACC_ADD,
		ACC_LOAD_P
	} acc_op_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     w_load;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

/* sv/bqd_coef.sv */
// Coefficient register bank written through the configuration port.
`timescale 1ns / 1ps
`default_nettype none

module bqd_coef
	import bqd_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wr_en,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_addr,
	input  wire logic [COEF_BITS-1:0]    cfg_data,
	output coef_t                        coef
);

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= COEF_ONE;
			coef_q.b1 <= COEF_ZERO;
			coef_q.b2 <= COEF_ZERO;
			coef_q.a1 <= COEF_ZERO;
			coef_q.a2 <= COEF_ZERO;
		end else if (cfg_wr_en) begin
			// Drop writes to unknown indexes
			case (cfg_addr)
				CFG_B0:  coef_q.b0 <= cfg_data;
				CFG_B1:  coef_q.b1 <= cfg_data;
				CFG_B2:  coef_q.b2 <= cfg_data;
				CFG_A1:  coef_q.a1 <= cfg_data;
				CFG_A2:  coef_q.a2 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coef = coef_q;

endmodule

`default_nettype wire

/* sv/bqd_dp.sv */
// Datapath: shared multiplier, accumulator, rounder and delay registers.
`timescale 1ns / 1ps
`default_nettype none

module bqd_dp
	import bqd_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire coef_t                         coef,
	input  wire cmd_t                          cmd,
	output status_t                            status,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	input  wire logic                          clear_state,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic                               out_valid,
	input  wire logic                          out_ready
);

	localparam logic signed [ACC_BITS-1:0] ACC_HALF =
		{{(ACC_BITS-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [DELAY_BITS-1:0] DLY_MAX = {1'b0, {(DELAY_BITS-1){1'b1}}};
	localparam logic signed [DELAY_BITS-1:0] DLY_MIN = {1'b1, {(DELAY_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [DELAY_BITS-1:0]  d1_q, d2_q, w_q;
	logic signed [PROD_BITS-1:0]   prod_q, prod_d;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [ACC_BITS-1:0]    rnd_sum, rnd_shift;
	logic signed [COEF_BITS-1:0]   mul_coef;
	logic signed [DELAY_BITS-1:0]  mul_dly;
	logic signed [DELAY_BITS-1:0]  w_next;
	logic signed [SAMPLE_BITS-1:0] y_next;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          out_valid_q;

	// Operand select; on the accept cycle the clear flag masks d1
	always_comb begin
		mul_coef = coef.a1;
		mul_dly  = d1_q;
		case (cmd.mul_sel)
			MUL_A1: begin
				mul_coef = coef.a1;
				mul_dly  = (cmd.load && clear_state) ? '0 : d1_q;
			end
			MUL_A2: begin
				mul_coef = coef.a2;
				mul_dly  = d2_q;
			end
			MUL_B0: begin
				mul_coef = coef.b0;
				mul_dly  = w_q;
			end
			MUL_B1: begin
				mul_coef = coef.b1;
				mul_dly  = d1_q;
			end
			MUL_B2: begin
				mul_coef = coef.b2;
				mul_dly  = d2_q;
			end
			default: begin
				mul_coef = coef.a1;
				mul_dly  = d1_q;
			end
		endcase
	end

	assign prod_d = PROD_BITS'(mul_coef) * PROD_BITS'(mul_dly);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.acc_op)
			ACC_LOAD_X: acc_q <= ACC_BITS'(sample_in) <<< COEF_FRAC_BITS;
			ACC_SUB:    acc_q <= acc_q - ACC_BITS'(prod_q);
			ACC_ADD:    acc_q <= acc_q + ACC_BITS'(prod_q);
			ACC_LOAD_P: acc_q <= ACC_BITS'(prod_q);
			default:    acc_q <= acc_q;
		endcase
	end

	// Round half up, then saturate; shared by w and y
	assign rnd_sum   = acc_q + ACC_HALF;
	assign rnd_shift = rnd_sum >>> COEF_FRAC_BITS;

	always_comb begin
		if (rnd_shift > ACC_BITS'(DLY_MAX)) begin
			w_next = DLY_MAX;
		end else if (rnd_shift < ACC_BITS'(DLY_MIN)) begin
			w_next = DLY_MIN;
		end else begin
			w_next = rnd_shift[DELAY_BITS-1:0];
		end
	end

	always_comb begin
		if (rnd_shift > ACC_BITS'(SMP_MAX)) begin
			y_next = SMP_MAX;
		end else if (rnd_shift < ACC_BITS'(SMP_MIN)) begin
			y_next = SMP_MIN;
		end else begin
			y_next = rnd_shift[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.w_load) begin
			w_q <= w_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (cmd.load && clear_state) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (cmd.finish) begin
			d2_q <= d1_q;
			d1_q <= w_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sample_out_q <= y_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign sample_out      = sample_out_q;
	assign out_valid       = out_valid_q;

endmodule

`default_nettype wire

/* sv/bqd_ctrl.sv */
// Controller state machine sequencing the five products of one sample.
`timescale 1ns / 1ps
`default_nettype none

module bqd_ctrl
	import bqd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_A2;
			end
			ST_A2:   state_d = ST_WSUM;
			ST_WSUM: state_d = ST_WSAT;
			ST_WSAT: state_d = ST_B0;
			ST_B0:   state_d = ST_B2;
			ST_B2:   state_d = ST_YSUM;
			ST_YSUM: state_d = ST_OUT;
			ST_OUT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_A1;
		cmd.acc_op  = ACC_HOLD;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load    = in_valid;
				cmd.mul_en  = in_valid;
				cmd.mul_sel = MUL_A1;
				cmd.acc_op  = in_valid ? ACC_LOAD_X : ACC_HOLD;
			end
			ST_A2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_A2;
				cmd.acc_op  = ACC_SUB;
			end
			ST_WSUM: begin
				cmd.acc_op = ACC_SUB;
			end
			ST_WSAT: begin
				cmd.w_load  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_B1;
			end
			ST_B0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_B0;
				cmd.acc_op  = ACC_LOAD_P;
			end
			ST_B2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_B2;
				cmd.acc_op  = ACC_ADD;
			end
			ST_YSUM: begin
				cmd.acc_op = ACC_ADD;
			end
			ST_OUT: begin
				cmd.finish = status.out_free;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* sv/biquad_iir_filter.sv */
// Top level of the direct form II biquad section.
// sample_out is registered on leaving ST_OUT, after states ST_A2 to ST_YSUM.
// A word is taken only in ST_IDLE, once the last is through; the single shared 24x32
// multiplier takes five products per sample plus the rounding steps for w and y.
// A result held at the output stalls the section only once the next result is ready.
// Reset (arst_n low): delays zero, b0 = 1.0, other coefficients zero (pass-through).
`timescale 1ns / 1ps
`default_nettype none

module biquad_iir_filter
	import bqd_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input word
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	input  wire logic                          clear_state,
	// Output word
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	// Coefficient writes
	input  wire logic                          cfg_wr_en,
	input  wire logic [CFG_IDX_BITS-1:0]       cfg_addr,
	input  wire logic [COEF_BITS-1:0]          cfg_data
);

	coef_t   coef;
	cmd_t    cmd;
	status_t status;

	// Hold the five coefficients; write them only while the section is idle
	bqd_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// Sequence: accept and start a1*d1, then a2*d2, form and saturate w,
	// then b1*d1, b0*w and b2*d2, round y and advance the delay line
	bqd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Shared multiplier, accumulator, rounder, delay and output registers
	bqd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.coef        (coef),
		.cmd         (cmd),
		.status      (status),
		.sample_in   (sample_in),
		.clear_state (clear_state),
		.sample_out  (sample_out),
		.out_valid   (out_valid),
		.out_ready   (out_ready)
	);

endmodule

`default_nettype wire

/* test/biquad_iir_filter_tb.sv */
// Self-checking testbench for the direct form II biquad section.
`timescale 1ns / 1ps

module biquad_iir_filter_tb;
	import bqd_pkg::*;

	// Run limits
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_SLACK = 12;	// settling margin after the last word comes back
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 80;
	localparam int MAX_REPORTS = 40;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
	localparam int HALF_LSB = 1 << (COEF_FRAC_BITS - 1);

	// Indexes past the last coefficient; writes there must change nothing
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = CFG_IDX_BITS'(CFG_REGS);
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = '1;

	typedef enum int {
		COEF_STABLE,	// poles well inside the unit circle
		COEF_WILD,	// any 24-bit pattern, usually unstable and saturating
		COEF_CORNER	// extremes, zero, unity and plus or minus one LSB
	} coef_style_t;

	// Golden model of the section plus the queue of outstanding output words
	class biquad_scoreboard;
		coef_t                          coefs;
		logic signed [DELAY_BITS-1:0]   delay_one;
		logic signed [DELAY_BITS-1:0]   delay_two;
		logic signed [SAMPLE_BITS-1:0]  expected_out[$];
		int mismatches;
		int samples;
		int clears;
		int checked;

		function new();
			coefs = '{b0: COEF_ONE, b1: COEF_ZERO, b2: COEF_ZERO, a1: COEF_ZERO, a2: COEF_ZERO};
			delay_one = '0;
			delay_two = '0;
		endfunction

		function void write_coef(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_BITS-1:0] data);
			case (idx)
				CFG_B0: coefs.b0 = data;
				CFG_B1: coefs.b1 = data;
				CFG_B2: coefs.b2 = data;
				CFG_A1: coefs.a1 = data;
				CFG_A2: coefs.a2 = data;
				default: ;
			endcase
		endfunction

		// Round half up, then drop the coefficient fraction bits
		function longint round_scale(longint acc);
			return (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
		endfunction

		function longint saturate(longint v, int bits);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (bits - 1)) - 1;
			lo = -hi - 1;
			return (v > hi) ? hi : ((v < lo) ? lo : v);
		endfunction

		function void note_sample(logic signed [SAMPLE_BITS-1:0] x, logic clr);
			longint acc;
			longint w;
			longint y;
			if (clr) begin
				delay_one = '0;
				delay_two = '0;
				clears++;
			end
			acc = (longint'(x) <<< COEF_FRAC_BITS)
				- longint'($signed(coefs.a1)) * longint'(delay_one)
				- longint'($signed(coefs.a2)) * longint'(delay_two);
			w = saturate(round_scale(acc), DELAY_BITS);
			acc = longint'($signed(coefs.b0)) * w
				+ longint'($signed(coefs.b1)) * longint'(delay_one)
				+ longint'($signed(coefs.b2)) * longint'(delay_two);
			y = saturate(round_scale(acc), SAMPLE_BITS);
			delay_two = delay_one;
			delay_one = w[DELAY_BITS-1:0];
			expected_out.push_back(y[SAMPLE_BITS-1:0]);
			samples++;
		endfunction

		function void check_result(logic signed [SAMPLE_BITS-1:0] got);
			logic signed [SAMPLE_BITS-1:0] want;
			if (expected_out.size() == 0) begin
				mismatches++;
				$display("%0t: sample_out expected none, actual %0d", $time, got);
				return;
			end
			want = expected_out.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: sample_out expected %0d, actual %0d", $time, want, got);
			end
		endfunction

		function int pending();
			return expected_out.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n      = 1'b0;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_in   = '0;
	logic                          clear_state = 1'b0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          cfg_wr_en   = 1'b0;
	logic [CFG_IDX_BITS-1:0]       cfg_addr    = '0;
	logic [COEF_BITS-1:0]          cfg_data    = '0;

	biquad_scoreboard sb;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	int settings;
	int cycle_count;

	biquad_iir_filter u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_in   (sample_in),
		.clear_state (clear_state),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample_out  (sample_out),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Monitor both handshakes on the values the block saw at this edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_sample(sample_in, clear_state);
		if (arst_n && out_valid && out_ready)
			sb.check_result(sample_out);
	end

	// Watchdog: a hung handshake must not run forever
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d words outstanding",
				$time, cycle_count, sb.pending());
			$display("Some tests failed");
			$finish;
		end
	end

	// Output side: when rx_idle is set, stall a random number of cycles before taking each word
	initial begin
		int stall;
		@(posedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one input word after an optional gap; return at the accepting edge.
	// Valid is left high so a back-to-back word never sees it drop in between.
	task automatic send_word(input logic signed [SAMPLE_BITS-1:0] s, input logic clr);
		int gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid    <= 1'b0;
			sample_in   <= SAMPLE_BITS'($urandom());	// noise while idle
			clear_state <= 1'($urandom());
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample_in   <= s;
		clear_state <= clr;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold off the sender until every outstanding word has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_coef(idx, data);
	endtask

	// Load a full coefficient set; optionally poke a spare index afterwards
	task automatic set_coefs(input coef_t c, input bit poke_spare);
		cfg_write(CFG_B0, c.b0);
		cfg_write(CFG_B1, c.b1);
		cfg_write(CFG_B2, c.b2);
		cfg_write(CFG_A1, c.a1);
		cfg_write(CFG_A2, c.a2);
		if (poke_spare)
			cfg_write(CFG_IDX_BITS'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
				COEF_BITS'($urandom()));
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	function automatic logic signed [COEF_BITS-1:0] pick_coef(coef_style_t style, int span);
		case (style)
			COEF_STABLE: return COEF_BITS'(int'($urandom_range(0, 2 * span)) - span);
			COEF_CORNER:
				case ($urandom_range(0, 5))
					0: return COEF_MAX;
					1: return COEF_MIN;
					2: return COEF_ZERO;
					3: return COEF_ONE;
					4: return COEF_BITS'(1);
					default: return '1;
				endcase
			default: return COEF_BITS'($urandom());
		endcase
	endfunction

	function automatic coef_t draw_coefs(coef_style_t style);
		coef_t c;
		// Stable set: |a1| <= 0.5, |a2| <= 0.4 keeps both poles inside the circle
		c.b0 = pick_coef(style, 1 << COEF_FRAC_BITS);
		c.b1 = pick_coef(style, 1 << COEF_FRAC_BITS);
		c.b2 = pick_coef(style, 1 << COEF_FRAC_BITS);
		c.a1 = pick_coef(style, 1 << (COEF_FRAC_BITS - 1));
		c.a2 = pick_coef(style, (2 << COEF_FRAC_BITS) / 5);
		return c;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3, 4: return SAMPLE_BITS'(int'($urandom_range(0, 8192)) - 4096);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	initial begin
		coef_t c;
		coef_style_t style;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pass-through after reset: extremes and the words around zero
		send_word('0, 1'b0);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MIN, 1'b0);
		send_word('1, 1'b0);
		send_word(SAMPLE_BITS'(1), 1'b1);
		drain();

		// All gains at full scale, feedback at its most negative: drives w and y into
		// saturation, then clear the delays mid-stream
		set_coefs('{b0: COEF_MAX, b1: COEF_MAX, b2: COEF_MAX, a1: COEF_MIN, a2: COEF_MIN}, 1'b1);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_MIN, 1'b1);
		send_word(SAMPLE_MAX, 1'b0);
		drain();

		set_coefs('{b0: COEF_MIN, b1: COEF_MIN, b2: COEF_MIN, a1: COEF_MAX, a2: COEF_MAX}, 1'b0);
		send_word(SAMPLE_MIN, 1'b0);
		send_word(SAMPLE_MIN, 1'b0);
		send_word(SAMPLE_MAX, 1'b0);
		send_word(SAMPLE_BITS'(1), 1'b1);
		send_word('0, 1'b0);
		drain();

		// Gain of -2.0: the most negative input overflows to positive full scale
		set_coefs('{b0: COEF_MIN, b1: COEF_ZERO, b2: COEF_ZERO, a1: COEF_ZERO, a2: COEF_ZERO},
			1'b1);
		send_word(SAMPLE_MIN, 1'b1);
		send_word(SAMPLE_MAX, 1'b0);
		drain();

		// One-LSB gain: land exactly on the rounding half-way point both sides of zero
		set_coefs('{b0: COEF_BITS'(1), b1: COEF_ZERO, b2: COEF_ZERO, a1: COEF_ZERO,
			a2: COEF_ZERO}, 1'b0);
		send_word(SAMPLE_BITS'(HALF_LSB), 1'b0);
		send_word(SAMPLE_BITS'(-HALF_LSB), 1'b0);
		send_word(SAMPLE_BITS'(-HALF_LSB - 1), 1'b0);
		send_word(SAMPLE_BITS'(HALF_LSB - 1), 1'b0);

		// Random phases: fresh coefficients and idling pattern each time
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph % 4)
				1: style = COEF_WILD;
				2: style = COEF_CORNER;
				default: style = COEF_STABLE;
			endcase
			c = draw_coefs(style);
			set_coefs(c, $urandom_range(0, 2) == 0);
			tx_idle = (ph == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
			rx_idle = (ph == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// Hold the sender until the pipe is empty, then carry on mid-phase
				if (i == PHASE_WORDS / 2 && (ph == 1 || $urandom_range(0, 1) == 1))
					drain();
				send_word(draw_sample(), (i == 0) || ($urandom_range(0, 15) == 0));
			end
		end

		drain();
		$display("Run covered %0d samples (%0d with delay clear) over %0d coefficient sets,",
			sb.samples, sb.clears, settings);
		$display("with %0d output words compared and %0d mismatches.", sb.checked,
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
